### rtl/irws_pkg.sv
// shared types and constants for the ir wall sensor sequencer
package irws_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int NUM_SENSORS = 4;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_W     = 4;
  localparam int THR_W       = 13;
  localparam int EMIT_W      = 4;
  localparam int DIR_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int CMP_W       = (DIFF_W > THR_W) ? DIFF_W : THR_W;

  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(NUM_PHASES - 1);
  localparam logic [PHASE_W-1:0] DARK_PHASE = PHASE_W'(NUM_PHASES - 2);

  // input operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_DONE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_LEFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_RIGHT = 2'd3;

  // direction bit positions
  localparam int DIR_LEFT_BIT  = 0;
  localparam int DIR_FL_BIT    = 1;
  localparam int DIR_FR_BIT    = 2;
  localparam int DIR_RIGHT_BIT = 3;

  typedef logic [SAMPLE_BITS-1:0]  sample_t;
  typedef logic signed [THR_W-1:0] thr_t;

  // control from the phase sequencer to the classifier
  typedef struct packed {
    logic                            lit_we;
    logic [$clog2(NUM_SENSORS)-1:0]  lit_idx;
    logic                            eval;
  } seq_ctrl_t;

endpackage

### rtl/irws_phase_seq.sv
// phase counter, emitter drive, conversion trigger and sticky error flag
module irws_phase_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic                              op,
  output irws_pkg::seq_ctrl_t               ctrl,
  output logic [irws_pkg::EMIT_W-1:0]       emitter_nxt,
  output logic                              trigger,
  output logic                              error_nxt
);
  import irws_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [EMIT_W-1:0]  emitter_r;
  logic               error_r;
  logic [PHASE_W-1:0] phase_inc;

  assign phase_inc = (phase_r == LAST_PHASE) ? '0 : phase_r + PHASE_W'(1);

  always_comb begin
    phase_nxt   = phase_r;
    emitter_nxt = emitter_r;
    trigger     = 1'b0;
    error_nxt   = error_r;
    ctrl        = '0;
    if (op == OP_TICK) begin
      phase_nxt = phase_inc;
      if (phase_inc[0]) begin
        trigger = 1'b1;
      end else if (phase_inc < DARK_PHASE) begin
        emitter_nxt = EMIT_W'(1) << phase_inc[PHASE_W-1:1];
      end else begin
        emitter_nxt = '0;
      end
    end else begin
      // completions only belong to odd phases
      if (!phase_r[0] || phase_r > LAST_PHASE) begin
        error_nxt = 1'b1;
      end else if (phase_r < LAST_PHASE) begin
        ctrl.lit_we  = 1'b1;
        ctrl.lit_idx = phase_r[$clog2(NUM_SENSORS):1];
      end else begin
        ctrl.eval = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      emitter_r <= '0;
      error_r   <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      emitter_r <= emitter_nxt;
      error_r   <= error_nxt;
    end
  end

endmodule

### rtl/irws_classify.sv
// threshold registers, lit reading store and open-direction compare
module irws_classify (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [irws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irws_pkg::THR_W-1:0]        cfg_data,
  input  logic                              step,
  input  irws_pkg::seq_ctrl_t               ctrl,
  input  logic [irws_pkg::SAMPLE_BITS-1:0]  sample [irws_pkg::NUM_SENSORS],
  output logic [irws_pkg::DIR_W-1:0]        dir_nxt,
  output logic                              dir_valid,
  output logic                              dir_changed
);
  import irws_pkg::*;

  thr_t    thr_r [NUM_SENSORS];
  sample_t lit_r [NUM_SENSORS];
  logic [DIR_W-1:0]       last_dir_r;
  logic [NUM_SENSORS-1:0] open_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SENSORS; k++) begin
        thr_r[k] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRONT_LEFT:  thr_r[0] <= cfg_data;
        CFG_LEFT:        thr_r[1] <= cfg_data;
        CFG_RIGHT:       thr_r[2] <= cfg_data;
        CFG_FRONT_RIGHT: thr_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step && ctrl.lit_we) begin
      lit_r[ctrl.lit_idx] <= sample[ctrl.lit_idx];
    end
  end

  // lit minus dark, compared signed against the threshold
  always_comb begin
    for (int k = 0; k < NUM_SENSORS; k++) begin
      logic signed [CMP_W-1:0] diff;
      diff = CMP_W'(signed'({1'b0, lit_r[k]})) - CMP_W'(signed'({1'b0, sample[k]}));
      open_s[k] = diff > CMP_W'(thr_r[k]);
    end
  end

  always_comb begin
    dir_nxt     = last_dir_r;
    dir_valid   = 1'b0;
    dir_changed = 1'b0;
    if (ctrl.eval) begin
      dir_nxt[DIR_FL_BIT]    = open_s[0];
      dir_nxt[DIR_LEFT_BIT]  = open_s[1];
      dir_nxt[DIR_RIGHT_BIT] = open_s[2];
      dir_nxt[DIR_FR_BIT]    = open_s[3];
      dir_valid   = 1'b1;
      dir_changed = dir_nxt != last_dir_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dir_r <= '0;
    end else if (step) begin
      last_dir_r <= dir_nxt;
    end
  end

endmodule

### rtl/ir_wall_sensor_sequencer_unit.sv
// top level: input register, sequencer, classifier and result register
//
//   channel  direction  handshake              payload
//   in_      in         in_valid / in_stall    op, four 12-bit sensor samples
//   out_     out        out_valid / out_stall  emitter, trigger, dirs, error flag
//   cfg_     in         cfg_valid / cfg_ready  2-bit index, 13-bit threshold
//
// an item goes from input transfer into the input register, then through the
// sequencer and compare into the result register. one item per cycle is
// sustained while out_stall is low. rst_n is synchronous and clears phase,
// emitter, direction, error state and thresholds; cfg_ready is always high.
// a stall on the result side backs up through the input register into in_stall.
module ir_wall_sensor_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [irws_pkg::SAMPLE_BITS-1:0]  in_sample_front_left,
  input  logic [irws_pkg::SAMPLE_BITS-1:0]  in_sample_left,
  input  logic [irws_pkg::SAMPLE_BITS-1:0]  in_sample_right,
  input  logic [irws_pkg::SAMPLE_BITS-1:0]  in_sample_front_right,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [irws_pkg::EMIT_W-1:0]       out_emitter_pattern,
  output logic                              out_adc_trigger,
  output logic [irws_pkg::DIR_W-1:0]        out_avail_dir,
  output logic                              out_dir_valid,
  output logic                              out_dir_changed,
  output logic                              out_adc_error,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [irws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irws_pkg::THR_W-1:0]        cfg_data
);
  import irws_pkg::*;

  logic      s1_valid_r;
  logic      s1_op_r;
  sample_t   s1_sample_r [NUM_SENSORS];
  logic      out_valid_r;
  logic      out_free;
  logic      step;
  logic      in_take;
  seq_ctrl_t ctrl;

  logic [EMIT_W-1:0] emitter_nxt;
  logic              trigger;
  logic              error_nxt;
  logic [DIR_W-1:0]  dir_nxt;
  logic              dir_valid;
  logic              dir_changed;

  logic [EMIT_W-1:0] out_emitter_r;
  logic              out_trigger_r;
  logic [DIR_W-1:0]  out_dir_r;
  logic              out_dir_valid_r;
  logic              out_dir_changed_r;
  logic              out_error_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign step      = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || out_free) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r        <= in_op;
      s1_sample_r[0] <= in_sample_front_left;
      s1_sample_r[1] <= in_sample_left;
      s1_sample_r[2] <= in_sample_right;
      s1_sample_r[3] <= in_sample_front_right;
    end
  end

  irws_phase_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .op          (s1_op_r),
    .ctrl        (ctrl),
    .emitter_nxt (emitter_nxt),
    .trigger     (trigger),
    .error_nxt   (error_nxt)
  );

  irws_classify u_cls (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .step        (step),
    .ctrl        (ctrl),
    .sample      (s1_sample_r),
    .dir_nxt     (dir_nxt),
    .dir_valid   (dir_valid),
    .dir_changed (dir_changed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_emitter_r     <= emitter_nxt;
      out_trigger_r     <= trigger;
      out_dir_r         <= dir_nxt;
      out_dir_valid_r   <= dir_valid;
      out_dir_changed_r <= dir_changed;
      out_error_r       <= error_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_emitter_pattern = out_emitter_r;
  assign out_adc_trigger     = out_trigger_r;
  assign out_avail_dir       = out_dir_r;
  assign out_dir_valid       = out_dir_valid_r;
  assign out_dir_changed     = out_dir_changed_r;
  assign out_adc_error       = out_error_r;

endmodule
